### rtl/sfra_pkg.sv
package sfra_pkg;

  // Sizes of the pattern window and of the replacement text
  localparam int MAX_PATTERN_BYTES     = 8;
  localparam int MAX_REPLACEMENT_BYTES = 8;
  localparam int WIN_IDX_W             = 3;
  localparam int LEN_W                 = 4;
  localparam int CFG_W                 = 64;

  // Depth of the job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PATTERN    = 2'd0,
    REG_SEARCH_LEN = 2'd1,
    REG_REPL_TEXT  = 2'd2,
    REG_REPL_LEN   = 2'd3
  } sfra_reg_t;

  // One job for the back end: up to eight bytes to emit, oldest in bits 7:0.
  // A job with no bytes and the last flag set gives the empty end marker.
  typedef struct packed {
    logic [CFG_W-1:0] bytes;
    logic [LEN_W-1:0] count;
    logic             last;
  } sfra_job_t;

endpackage

### rtl/stream_find_replace_all.sv
// Streaming find-and-replace-all over a byte stream.
// Input channel (in_valid/in_ready): one source byte per item, in_last_byte
// marks the final byte of a stream. Output channel (out_valid/out_ready):
// one rewritten byte per item; out_run_last flags the final item caused by
// an input, out_stream_end the final item of the stream, and an item with
// out_byte_valid low is the empty end marker.
// Configuration (cfg_we/cfg_index/cfg_wdata): pattern, search length,
// replacement text, replacement length; write only while the block is idle.
// Writing the search length drops any bytes held in the window.
// Each item passes the job queue, the job register and the output register
// before its first result appears. Throughput: one input item per cycle
// and one result per cycle while the receiver is ready; each result of an
// item, the end marker too, is one output item. A four-entry job queue
// absorbs replacement bursts, and the input stalls only when that queue is full.
// Reset empties the window, the job queue and the output register and loads
// the register defaults (search length 1, everything else zero).
// When the receiver stalls, the output item holds and the queue fills.
module stream_find_replace_all import sfra_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_out_byte,
  output logic             out_byte_valid,
  output logic             out_run_last,
  output logic             out_stream_end
);

  logic      job_push;
  sfra_job_t job_in;
  logic      q_full;
  logic      q_pop;
  logic      q_valid;
  sfra_job_t job_out;

  // Front: window update and classification
  sfra_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .job_push     (job_push),
    .job_data     (job_in)
  );

  // Job queue
  sfra_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .din       (job_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (job_out)
  );

  // Back: byte emission
  sfra_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (job_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_stream_end (out_stream_end)
  );

endmodule

### rtl/sfra_front.sv
module sfra_front import sfra_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_last_byte,
  input  logic             q_full,
  output logic             job_push,
  output sfra_job_t        job_data
);

  logic [CFG_W-1:0] pattern_r;
  logic [LEN_W-1:0] slen_r;
  logic [CFG_W-1:0] repl_r;
  logic [LEN_W-1:0] rlen_r;
  logic [LEN_W-1:0] held_r;
  logic [LEN_W-1:0] held_nxt;
  logic [7:0]       win_r     [MAX_PATTERN_BYTES];
  logic [7:0]       win_nxt   [MAX_PATTERN_BYTES];
  logic [7:0]       win_new   [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] byte_ok;

  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] rlen;
  logic [LEN_W-1:0] cnt;
  logic [CFG_W-1:0] win_flat;
  logic             accept;
  logic             full;
  logic             hit;
  sfra_reg_t        reg_sel;

  assign reg_sel  = sfra_reg_t'(cfg_index);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Effective lengths after clamping
  always_comb begin
    if (slen_r == '0) begin
      plen = LEN_W'(1);
    end else if (slen_r > LEN_W'(MAX_PATTERN_BYTES)) begin
      plen = LEN_W'(MAX_PATTERN_BYTES);
    end else begin
      plen = slen_r;
    end
    if (rlen_r > LEN_W'(MAX_REPLACEMENT_BYTES)) begin
      rlen = LEN_W'(MAX_REPLACEMENT_BYTES);
    end else begin
      rlen = rlen_r;
    end
  end

  // Window with the new byte in place, and per-byte pattern compare
  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      win_new[i] = (held_r[WIN_IDX_W-1:0] == WIN_IDX_W'(i)) ? in_data_byte : win_r[i];
      win_flat[8*i +: 8] = win_new[i];
      byte_ok[i] = (LEN_W'(i) >= plen) || (win_new[i] == pattern_r[8*i +: 8]);
    end
  end

  assign cnt  = held_r + LEN_W'(1);
  assign full = (cnt == plen);
  assign hit  = full && (&byte_ok);

  // Classify the item into a job and the next window state
  always_comb begin
    held_nxt       = cnt;
    job_data.bytes = win_flat;
    job_data.count = '0;
    job_data.last  = in_last_byte;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      win_nxt[i] = win_new[i];
    end
    priority if (hit) begin
      job_data.bytes = repl_r;
      job_data.count = rlen;
      held_nxt       = '0;
    end else if (full && !in_last_byte) begin
      // oldest byte leaves, the rest move down one place
      job_data.count = LEN_W'(1);
      held_nxt       = plen - LEN_W'(1);
      for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
        win_nxt[i] = win_new[i+1];
      end
    end else if (in_last_byte) begin
      job_data.count = cnt;
      held_nxt       = '0;
    end else begin
      held_nxt = cnt;
    end
  end

  assign job_push = accept && ((job_data.count != '0) || in_last_byte);

  // Configuration registers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      slen_r    <= LEN_W'(1);
      repl_r    <= '0;
      rlen_r    <= '0;
      held_r    <= '0;
    end else begin
      if (accept) begin
        held_r <= held_nxt;
      end
      if (cfg_we) begin
        unique case (reg_sel)
          REG_PATTERN:    pattern_r <= cfg_wdata;
          REG_SEARCH_LEN: begin
            slen_r <= cfg_wdata[LEN_W-1:0];
            held_r <= '0;
          end
          REG_REPL_TEXT:  repl_r <= cfg_wdata;
          REG_REPL_LEN:   rlen_r <= cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Window bytes
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // The fill count stays below the pattern length
  a_held_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    held_r < plen) else $error("window fill count reached pattern length");

endmodule

### rtl/sfra_queue.sv
module sfra_queue import sfra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sfra_job_t din,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output sfra_job_t dout
);

  sfra_job_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = mem_r[rd_ptr_r];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + Q_CNT_W'(1);
        2'b01:   count_r <= count_r - Q_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !not_empty)) else $error("job queue read while empty");

endmodule

### rtl/sfra_back.sv
module sfra_back import sfra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  sfra_job_t q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [7:0] out_out_byte,
  output logic      out_byte_valid,
  output logic      out_run_last,
  output logic      out_stream_end
);

  logic             act_r;
  logic [CFG_W-1:0] bytes_r;
  logic [LEN_W-1:0] left_r;
  logic             last_r;

  logic             out_valid_r;
  logic [7:0]       byte_r;
  logic             bvalid_r;
  logic             run_last_r;
  logic             stream_end_r;

  logic can_emit;
  logic emit;
  logic fin;

  assign can_emit = !out_valid_r || out_ready;
  assign emit     = act_r && can_emit;
  assign fin      = (left_r <= LEN_W'(1));
  assign q_pop    = q_valid && (!act_r || (emit && fin));

  // Current job: one byte leaves per emitted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        act_r <= 1'b1;
      end else if (emit && fin) begin
        act_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      bytes_r <= q_data.bytes;
      left_r  <= q_data.count;
      last_r  <= q_data.last;
    end else if (emit) begin
      bytes_r <= bytes_r >> 8;
      left_r  <= left_r - LEN_W'(1);
    end
  end

  // Output register; an empty job gives the end marker with a zero byte
  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r       <= (left_r == '0) ? 8'h00 : bytes_r[7:0];
      bvalid_r     <= (left_r != '0);
      run_last_r   <= fin;
      stream_end_r <= fin && last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_out_byte   = byte_r;
  assign out_byte_valid = bvalid_r;
  assign out_run_last   = run_last_r;
  assign out_stream_end = stream_end_r;

  a_marker_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !bvalid_r |-> run_last_r && stream_end_r)
    else $error("end marker not flagged as stream end");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && stream_end_r |-> run_last_r)
    else $error("stream end without run last");

  a_job_len: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> left_r <= LEN_W'(MAX_PATTERN_BYTES))
    else $error("job byte count out of range");

endmodule
